// ===== rtl/sc_pkg.sv =====
// ----------------------------------------------------------------------------
// sc_pkg
// Shared widths, angle constants, stage structs and helpers for the
// sine/cosine polynomial core.
// ----------------------------------------------------------------------------
`default_nettype none

package sc_pkg;

  localparam int ANGLE_W    = 32;
  localparam int VALUE_W    = 32;
  localparam int FRAC_SHIFT = 15;
  localparam int Q31_SHIFT  = 31;
  localparam int RED_W      = 34;
  localparam int REM_W      = 48;
  localparam int X_W        = 32;
  localparam int X2_W       = 33;
  localparam int SUM_W      = 34;
  localparam int SQ_W       = 2 * X_W;
  localparam int PROD_W     = X_W + X2_W;
  localparam int MOD_CELLS  = 14;
  localparam int TERM_CELLS = 5;

  localparam logic [RED_W-1:0] HALF_PI_Q31 = 34'd3373259426;
  localparam logic [RED_W-1:0] PI_Q31      = HALF_PI_Q31 << 1;
  localparam logic [RED_W-1:0] TWO_PI_Q31  = HALF_PI_Q31 << 2;

  // multiple of 2*pi that lifts every angle to a non-negative value
  localparam logic [REM_W-1:0] REM_OFFSET = REM_W'(TWO_PI_Q31) << (MOD_CELLS - 1);

  localparam logic [VALUE_W-2:0] ONE_Q30 = 31'h4000_0000;

  // divisors giving 3!, 5!, 7!, 9! and 11!
  localparam int unsigned TERM_DIV [TERM_CELLS] = '{6, 20, 42, 72, 110};

  typedef struct packed {
    logic             vld;
    logic             cos;
    logic [REM_W-1:0] rem;
  } sc_mod_t;

  typedef struct packed {
    logic             vld;
    logic             neg;
    logic [X2_W-1:0]  x2;
    logic [SUM_W-1:0] pos;
    logic [SUM_W-1:0] negs;
  } sc_acc_t;

  typedef struct packed {
    sc_acc_t          acc;
    logic [X_W-1:0]   t;
  } sc_term_t;

  function automatic int unsigned sc_ctz(input int unsigned v);
    int unsigned n;
    bit          hit;
    n   = 0;
    hit = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (!hit) begin
        if (v[i]) begin
          hit = 1'b1;
        end else begin
          n = n + 1;
        end
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sc_mod_cell.sv =====
// ----------------------------------------------------------------------------
// sc_mod_cell
// One step of the modulo 2*pi reduction: conditional subtract of a shifted
// 2*pi, registered and handed to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sc_mod_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire sc_pkg::sc_mod_t in_stage,
  output sc_pkg::sc_mod_t      out_stage
);
  import sc_pkg::*;

  localparam logic [REM_W-1:0] SUB = REM_W'(TWO_PI_Q31) << SHIFT;

  sc_mod_t stage_r;
  sc_mod_t stage_nxt;

  always_comb begin
    stage_nxt = in_stage;
    if (in_stage.rem >= SUB) begin
      stage_nxt.rem = in_stage.rem - SUB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_stage = stage_r;

endmodule

`default_nettype wire

// ===== rtl/sc_term_cell.sv =====
// ----------------------------------------------------------------------------
// sc_term_cell
// One Taylor term: adds the incoming term to its running sum, then forms
// the next term as round(t * x2 / (DIV * 2^31)) over two registered stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sc_term_cell #(
  parameter int unsigned DIV    = 6,
  parameter bit          IN_NEG = 1'b0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire sc_pkg::sc_term_t in_term,
  output sc_pkg::sc_term_t      out_term
);
  import sc_pkg::*;

  localparam int unsigned SH    = sc_ctz(DIV);
  localparam int unsigned ODD   = DIV >> SH;
  localparam int unsigned LG    = $clog2(ODD);
  localparam int unsigned KSH   = X_W + LG;
  localparam int unsigned QW    = KSH + X_W;
  localparam int unsigned RW    = PROD_W + 3;
  localparam logic [RW-1:0] RND = RW'(DIV) << (Q31_SHIFT - 1);
  localparam logic [QW-1:0] RECIP = ((QW'(1) << KSH) + QW'(ODD - 1)) / QW'(ODD);

  sc_acc_t           acc_a_r;
  sc_acc_t           acc_a_nxt;
  sc_acc_t           acc_b_r;
  logic [PROD_W-1:0] prod_a_r;
  logic [PROD_W-1:0] prod_a_nxt;
  logic [RW-1:0]     rnd_sum;
  logic [X_W-1:0]    quo_in;
  logic [QW-1:0]     prod_b_r;
  logic [QW-1:0]     prod_b_nxt;

  always_comb begin
    acc_a_nxt = in_term.acc;
    if (IN_NEG) begin
      acc_a_nxt.negs = in_term.acc.negs + SUM_W'(in_term.t);
    end else begin
      acc_a_nxt.pos = in_term.acc.pos + SUM_W'(in_term.t);
    end
  end

  assign prod_a_nxt = PROD_W'(in_term.t) * PROD_W'(in_term.acc.x2);

  // rounding offset, power-of-two part of the divisor, then reciprocal
  assign rnd_sum    = RW'(prod_a_r) + RND;
  assign quo_in     = rnd_sum[Q31_SHIFT + SH +: X_W];
  assign prod_b_nxt = QW'(quo_in) * RECIP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_a_r.vld <= 1'b0;
      acc_b_r.vld <= 1'b0;
    end else if (en) begin
      acc_a_r <= acc_a_nxt;
      acc_b_r <= acc_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
    end
  end

  assign out_term.acc = acc_b_r;
  assign out_term.t   = prod_b_r[KSH +: X_W];

endmodule

`default_nettype wire

// ===== rtl/sine_cosine_polynomial_core.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_polynomial_core
// Throughput: one transfer per cycle when not stalled; 14 reduction cells and five term cells
// of two stages each make up most of the pipeline depth.
// A held result stalls the whole pipeline until it is taken.
// Reset (synchronous, active low) clears all stage valid bits and out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_cosine_polynomial_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [sc_pkg::ANGLE_W-1:0] in_angle,
  input  wire logic                              in_req_type,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [sc_pkg::VALUE_W-1:0]      out_value
);
  import sc_pkg::*;

  localparam int SQR_W = SQ_W + 1;

  logic               adv;
  logic [REM_W-1:0]   ang_q31;
  sc_mod_t            in_stage_r;
  sc_mod_t            in_stage_nxt;
  sc_mod_t            mod_chain [MOD_CELLS+1];

  logic [RED_W-1:0]   red_w;
  logic [RED_W-1:0]   red_pi;
  logic [RED_W-1:0]   red_half;
  logic               fold_vld_r;
  logic               fold_neg_r;
  logic [X_W-1:0]     fold_x_r;

  logic               sq_vld_r;
  logic               sq_neg_r;
  logic [X_W-1:0]     sq_x_r;
  logic [SQ_W-1:0]    sq_r;
  logic [SQR_W-1:0]   sq_rnd;

  sc_term_t           x2_stage_r;
  sc_term_t           x2_stage_nxt;
  sc_term_t           term_chain [TERM_CELLS+1];

  logic               fin_vld_r;
  logic               fin_neg_r;
  logic [SUM_W-1:0]   fin_pos_r;
  logic [SUM_W-1:0]   fin_negs_r;

  logic               dif_vld_r;
  logic               dif_neg_r;
  logic [SUM_W:0]     dif_r;

  logic [SUM_W:0]     inc_w;
  logic [SUM_W-1:0]   half_w;
  logic [VALUE_W-2:0] mag_w;
  logic [VALUE_W-1:0] value_nxt;
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // angle to Q31, cosine shift, lift to non-negative
  assign ang_q31 = {{(REM_W - ANGLE_W - FRAC_SHIFT){in_angle[ANGLE_W-1]}},
                    in_angle, {FRAC_SHIFT{1'b0}}};

  always_comb begin
    in_stage_nxt.vld = in_valid;
    in_stage_nxt.cos = in_req_type;
    in_stage_nxt.rem = ang_q31 + REM_OFFSET
                     - (in_req_type ? REM_W'(HALF_PI_Q31) : {REM_W{1'b0}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_stage_r.vld <= 1'b0;
    end else if (adv) begin
      in_stage_r <= in_stage_nxt;
    end
  end

  assign mod_chain[0] = in_stage_r;

  for (genvar g = 0; g < MOD_CELLS; g++) begin : g_mod
    sc_mod_cell #(
      .SHIFT (MOD_CELLS - 1 - g)
    ) u_mod (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_stage  (mod_chain[g]),
      .out_stage (mod_chain[g+1])
    );
  end

  // fold [0, 2*pi) into [0, pi/2]
  assign red_w    = mod_chain[MOD_CELLS].rem[RED_W-1:0];
  assign red_pi   = (red_w >= PI_Q31) ? TWO_PI_Q31 - red_w : red_w;
  assign red_half = (red_pi >= HALF_PI_Q31) ? PI_Q31 - red_pi : red_pi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_vld_r <= 1'b0;
      sq_vld_r   <= 1'b0;
    end else if (adv) begin
      fold_vld_r <= mod_chain[MOD_CELLS].vld;
      sq_vld_r   <= fold_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fold_neg_r <= (red_w > PI_Q31) ^ mod_chain[MOD_CELLS].cos;
      fold_x_r   <= red_half[X_W-1:0];
      sq_neg_r   <= fold_neg_r;
      sq_x_r     <= fold_x_r;
      sq_r       <= SQ_W'(fold_x_r) * SQ_W'(fold_x_r);
    end
  end

  assign sq_rnd = SQR_W'(sq_r) + (SQR_W'(1) << (Q31_SHIFT - 1));

  always_comb begin
    x2_stage_nxt.acc.vld  = sq_vld_r;
    x2_stage_nxt.acc.neg  = sq_neg_r;
    x2_stage_nxt.acc.x2   = sq_rnd[Q31_SHIFT +: X2_W];
    x2_stage_nxt.acc.pos  = {SUM_W{1'b0}};
    x2_stage_nxt.acc.negs = {SUM_W{1'b0}};
    x2_stage_nxt.t        = sq_x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x2_stage_r.acc.vld <= 1'b0;
    end else if (adv) begin
      x2_stage_r <= x2_stage_nxt;
    end
  end

  assign term_chain[0] = x2_stage_r;

  for (genvar g = 0; g < TERM_CELLS; g++) begin : g_term
    sc_term_cell #(
      .DIV    (TERM_DIV[g]),
      .IN_NEG (g % 2 == 1)
    ) u_term (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_term  (term_chain[g]),
      .out_term (term_chain[g+1])
    );
  end

  // last term is negative, then difference of the two sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r   <= 1'b0;
      dif_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      fin_vld_r   <= term_chain[TERM_CELLS].acc.vld;
      dif_vld_r   <= fin_vld_r;
      out_valid_r <= dif_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_neg_r   <= term_chain[TERM_CELLS].acc.neg;
      fin_pos_r   <= term_chain[TERM_CELLS].acc.pos;
      fin_negs_r  <= term_chain[TERM_CELLS].acc.negs + SUM_W'(term_chain[TERM_CELLS].t);
      dif_neg_r   <= fin_neg_r;
      dif_r       <= {1'b0, fin_pos_r} - {1'b0, fin_negs_r};
      out_value_r <= value_nxt;
    end
  end

  // Q31 to Q30 with rounding, clamp, sign
  assign inc_w  = dif_r + (SUM_W+1)'(1);
  assign half_w = inc_w[SUM_W:1];

  always_comb begin
    if (dif_r[SUM_W]) begin
      mag_w = {(VALUE_W-1){1'b0}};
    end else if (half_w > SUM_W'(ONE_Q30)) begin
      mag_w = ONE_Q30;
    end else begin
      mag_w = half_w[VALUE_W-2:0];
    end
    value_nxt = dif_neg_r ? {VALUE_W{1'b0}} - {1'b0, mag_w} : {1'b0, mag_w};
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

`default_nettype wire

// ===== rtl/sc_checker.sv =====
// ----------------------------------------------------------------------------
// sc_checker
// Port-level checks for the sine/cosine polynomial core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] out_value
);

  // held result keeps its value
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result changed while stalled");

  // result within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value <= 32'sd1073741824) && (out_value >= -32'sd1073741824))
    else $error("result out of range");

  // no input transfer while the output is blocked
  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // reset empties the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sine_cosine_polynomial_core sc_checker u_sc_checker (.*);

`default_nettype wire
